FILE: hdl/best_fit_block_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bfa_pkg.sv
// Package for the best-fit block allocator: item kinds, status codes,
// register indexes and the node memory write-enable group. No dependencies.
package bfa_pkg;

   localparam logic [1:0] KIND_INIT  = 2'd0;
   localparam logic [1:0] KIND_ALLOC = 2'd1;
   localparam logic [1:0] KIND_FREE  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;

   localparam logic CSR_BLOCK_COUNT = 1'b0;
   localparam logic CSR_BLOCK_SHIFT = 1'b1;

   localparam int CSR_DATA_W  = 9;
   localparam int SHIFT_W     = 4;
   localparam int BYTES_W     = 16;
   localparam int OFFSET_W    = 20;
   localparam int BLOCK_OUT_W = 8;
   // bytes rounded up to blocks at the smallest block size
   localparam int NEED_W      = 14;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd3;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;
   localparam logic [CSR_DATA_W-1:0] COUNT_RESET = 9'd256;

   typedef struct packed {
      logic parent;
      logic smaller;
      logic larger;
      logic size;
   } node_wen_type;

endpackage

FILE: hdl/bfa_node_mem.sv
// Node store of the free-range tree: parent, smaller, larger and size fields.
// One shared read address with registered data, one write address with
// per-field enables. Depends on bfa_pkg.
module bfa_node_mem #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                           clock,
   input  logic [$clog2(MAX_BLOCKS)-1:0]  raddr,
   input  logic [$clog2(MAX_BLOCKS)-1:0]  waddr,
   input  bfa_pkg::node_wen_type          wen,
   input  logic [$clog2(MAX_BLOCKS):0]    wparent,
   input  logic [$clog2(MAX_BLOCKS):0]    wsmaller,
   input  logic [$clog2(MAX_BLOCKS):0]    wlarger,
   input  logic [$clog2(MAX_BLOCKS):0]    wsize,
   output logic [$clog2(MAX_BLOCKS):0]    rd_parent,
   output logic [$clog2(MAX_BLOCKS):0]    rd_smaller,
   output logic [$clog2(MAX_BLOCKS):0]    rd_larger,
   output logic [$clog2(MAX_BLOCKS):0]    rd_size
);
   import bfa_pkg::*;

   localparam int NW = $clog2(MAX_BLOCKS) + 1;

   logic [NW-1:0] mem_parent  [MAX_BLOCKS];
   logic [NW-1:0] mem_smaller [MAX_BLOCKS];
   logic [NW-1:0] mem_larger  [MAX_BLOCKS];
   logic [NW-1:0] mem_size    [MAX_BLOCKS];
   logic [NW-1:0] rd_parent_ff, rd_smaller_ff, rd_larger_ff, rd_size_ff;

   always_ff @(posedge clock) begin
      if (wen.parent) begin
         mem_parent[waddr] <= wparent;
      end
      if (wen.smaller) begin
         mem_smaller[waddr] <= wsmaller;
      end
      if (wen.larger) begin
         mem_larger[waddr] <= wlarger;
      end
      if (wen.size) begin
         mem_size[waddr] <= wsize;
      end
      rd_parent_ff  <= mem_parent[raddr];
      rd_smaller_ff <= mem_smaller[raddr];
      rd_larger_ff  <= mem_larger[raddr];
      rd_size_ff    <= mem_size[raddr];
   end

   assign rd_parent  = rd_parent_ff;
   assign rd_smaller = rd_smaller_ff;
   assign rd_larger  = rd_larger_ff;
   assign rd_size    = rd_size_ff;

endmodule

FILE: hdl/best_fit_block_allocator.sv
// Best-fit block allocator over a pool of equal blocks.
// Items come in on req_* (valid/stall); each gives exactly one item on rsp_*.
// kind 0 resets the pool to one free range (block_count/block_shift taken
// here), kind 1 allocates, kind 2 frees a range at a byte offset.
// The block works on one item at a time; req_stall is high from acceptance
// until the result is loaded into the rsp output register, which then holds
// while rsp_stall is high. A new item is taken while a result still waits.
// Init sets up the pool, then marks every block of the new pool. Allocate
// walks the tree, does the remove/reinsert walks and marks each block it
// hands out. Free scans the marks forward to the range end and backwards
// to the previous range start (registered mark reads), then does the tree
// walks and marks every block of the merged range.
// The tree walks are bounded by the single node memory port: one node read
// per tree step.
// Reset (synchronous) empties the tree and gives an empty pool; allocate then
// answers no space and free answers bad free until an init item arrives.
// csr_* writes take effect at the next init.
`include "best_fit_block_allocator_defines.svh"

module best_fit_block_allocator #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [bfa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [bfa_pkg::BYTES_W-1:0]     req_request_bytes,
   input  logic [bfa_pkg::OFFSET_W-1:0]    req_free_offset,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [bfa_pkg::BLOCK_OUT_W-1:0] rsp_block_index,
   output logic [bfa_pkg::OFFSET_W-1:0]    rsp_byte_offset
);
   import bfa_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int NW = IW + 1;
   localparam logic [NW-1:0] NIL = NW'(2 * MAX_BLOCKS - 1);
   localparam logic [NW-1:0] MAXN = NW'(MAX_BLOCKS);

   localparam logic [5:0] S_IDLE = 6'd0,  S_DISP = 6'd1,  S_A1  = 6'd2,  S_A2  = 6'd3,
                          S_AX   = 6'd4,  S_A3   = 6'd5,  S_A4  = 6'd6,  S_A5  = 6'd7,
                          S_A6   = 6'd8,  S_F1   = 6'd9,  S_F2  = 6'd10, S_F3  = 6'd11,
                          S_F4   = 6'd12, S_F4B  = 6'd13, S_F5  = 6'd14, S_F6  = 6'd15,
                          S_F6B  = 6'd16, S_F7   = 6'd17, S_F8  = 6'd18, S_I0  = 6'd19,
                          S_I1   = 6'd20, S_I2   = 6'd21, S_I3  = 6'd22, S_I4  = 6'd23,
                          S_R0   = 6'd24, S_R1   = 6'd25, S_R2  = 6'd26, S_R3  = 6'd27,
                          S_R4   = 6'd28, S_R5   = 6'd29, S_R6  = 6'd30, S_R7  = 6'd31,
                          S_MK0  = 6'd32, S_MK1  = 6'd33, S_OUT = 6'd34, S_FC  = 6'd35,
                          S_F1B  = 6'd36, S_F2B  = 6'd37, S_F3B = 6'd38, S_F5B = 6'd39;

   function automatic logic is_node(input logic [NW-1:0] x);
      return 32'(x) < MAX_BLOCKS;
   endfunction

   // control
   logic [5:0] state_ff, state_in, ret_ins_ff, ret_ins_in, ret_rm_ff, ret_rm_in;
   logic [CSR_DATA_W-1:0] cfg_count_ff, cfg_count_in;
   logic [SHIFT_W-1:0] cfg_shift_ff, cfg_shift_in, pool_shift_ff, pool_shift_in;
   logic [NW-1:0] pool_count_ff, pool_count_in, root_ff, root_in;
   logic rsp_valid_ff, rsp_valid_in;

   // block marks; entries at or beyond the pool size are never read
   logic start_mem [MAX_BLOCKS];
   logic used_mem  [MAX_BLOCKS];
   logic start_rd_ff, used_rd_ff;

   // work registers
   logic [1:0] kind_ff, kind_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [NW-1:0] cur_ff, cur_in, best_ff, best_in, steps_ff, steps_in;
   logic [NW-1:0] blk_ff, blk_in, end_ff, end_in, len_ff, len_in, nxt_ff, nxt_in;
   logic [NW-1:0] ins_from_ff, ins_from_in, ins_node_ff, ins_node_in;
   logic [NW-1:0] ins_size_ff, ins_size_in, ins_steps_ff, ins_steps_in;
   logic [NW-1:0] rm_node_ff, rm_node_in, rm_par_ff, rm_par_in;
   logic [NW-1:0] rm_sm_ff, rm_sm_in, rm_lg_ff, rm_lg_in;
   logic [NW-1:0] mk_first_ff, mk_first_in;
   logic [NEED_W-1:0] mk_len_ff, mk_len_in, mk_k_ff, mk_k_in;
   logic mk_used_ff, mk_used_in;
   logic [1:0] res_status_ff, res_status_in;
   logic [NW-1:0] res_blk_ff, res_blk_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [BLOCK_OUT_W-1:0] rsp_block_ff, rsp_block_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   // mark writes and reads
   logic mk_we, mk_start_val, mk_used_val;
   logic [IW-1:0] mk_idx, mk_raddr;

   // node memory
   logic [NW-1:0] raddr, waddr, wparent, wsmaller, wlarger, wsize;
   node_wen_type wen;
   logic [NW-1:0] rd_parent, rd_smaller, rd_larger, rd_size;

   // scratch
   logic [16:0] round_sum;
   logic [31:0] tmp32, nx32;
   logic [NW-1:0] next_node;

   bfa_node_mem #(.MAX_BLOCKS(MAX_BLOCKS)) u_nodes (
      .clock      (clock),
      .raddr      (raddr[IW-1:0]),
      .waddr      (waddr[IW-1:0]),
      .wen        (wen),
      .wparent    (wparent),
      .wsmaller   (wsmaller),
      .wlarger    (wlarger),
      .wsize      (wsize),
      .rd_parent  (rd_parent),
      .rd_smaller (rd_smaller),
      .rd_larger  (rd_larger),
      .rd_size    (rd_size)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_block_ff;
   assign rsp_byte_offset = rsp_offset_ff;

   always_comb begin
      state_in      = state_ff;
      ret_ins_in    = ret_ins_ff;
      ret_rm_in     = ret_rm_ff;
      cfg_count_in  = cfg_count_ff;
      cfg_shift_in  = cfg_shift_ff;
      pool_count_in = pool_count_ff;
      pool_shift_in = pool_shift_ff;
      root_in       = root_ff;
      rsp_valid_in  = rsp_valid_ff;
      kind_in       = kind_ff;
      bytes_in      = bytes_ff;
      offset_in     = offset_ff;
      need_in       = need_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      steps_in      = steps_ff;
      blk_in        = blk_ff;
      end_in        = end_ff;
      len_in        = len_ff;
      nxt_in        = nxt_ff;
      ins_from_in   = ins_from_ff;
      ins_node_in   = ins_node_ff;
      ins_size_in   = ins_size_ff;
      ins_steps_in  = ins_steps_ff;
      rm_node_in    = rm_node_ff;
      rm_par_in     = rm_par_ff;
      rm_sm_in      = rm_sm_ff;
      rm_lg_in      = rm_lg_ff;
      mk_first_in   = mk_first_ff;
      mk_len_in     = mk_len_ff;
      mk_k_in       = mk_k_ff;
      mk_used_in    = mk_used_ff;
      res_status_in = res_status_ff;
      res_blk_in    = res_blk_ff;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_offset_in = rsp_offset_ff;

      mk_we        = 1'b0;
      mk_idx       = '0;
      mk_raddr     = '0;
      mk_start_val = 1'b0;
      mk_used_val  = 1'b0;
      raddr        = '0;
      waddr        = '0;
      wen          = '0;
      wparent      = NIL;
      wsmaller     = NIL;
      wlarger      = NIL;
      wsize        = '0;
      round_sum    = '0;
      tmp32        = '0;
      nx32         = '0;
      next_node    = NIL;

      if (csr_write_enable) begin
         if (csr_index == CSR_BLOCK_COUNT) begin
            cfg_count_in = csr_write_data;
         end else begin
            cfg_shift_in = csr_write_data[SHIFT_W-1:0];
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               bytes_in  = req_request_bytes;
               offset_in = req_free_offset;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            res_status_in = ST_OK;
            res_blk_in    = '0;
            state_in      = S_OUT;
            case (kind_ff)
               KIND_INIT: begin
                  tmp32 = (32'(cfg_count_ff) < MAX_BLOCKS) ? 32'(cfg_count_ff)
                                                            : 32'(MAX_BLOCKS);
                  tmp32 = tmp32 & ~32'h7;
                  pool_count_in = NW'(tmp32);
                  if (cfg_shift_ff < SHIFT_MIN) begin
                     pool_shift_in = SHIFT_MIN;
                  end else if (cfg_shift_ff > SHIFT_MAX) begin
                     pool_shift_in = SHIFT_MAX;
                  end else begin
                     pool_shift_in = cfg_shift_ff;
                  end
                  root_in     = NIL;
                  mk_first_in = '0;
                  mk_len_in   = NEED_W'(tmp32);
                  mk_used_in  = 1'b0;
                  if (tmp32 != 32'd0) begin
                     waddr    = '0;
                     wen      = '1;
                     wsize    = NW'(tmp32);
                     root_in  = '0;
                     // whole pool becomes one free range
                     state_in = S_MK0;
                  end
               end
               KIND_ALLOC: begin
                  round_sum = 17'(bytes_ff) + ((17'(1) << pool_shift_ff) - 17'(1));
                  need_in   = NEED_W'(round_sum >> pool_shift_ff);
                  cur_in    = root_ff;
                  best_in   = NIL;
                  steps_in  = '0;
                  if (bytes_ff == '0 || !is_node(root_ff)) begin
                     res_status_in = ST_NOSPACE;
                  end else begin
                     state_in = S_A1;
                  end
               end
               KIND_FREE: begin
                  tmp32 = 32'(offset_ff) >> pool_shift_ff;
                  if (tmp32 >= 32'(pool_count_ff)) begin
                     res_status_in = ST_BADFREE;
                  end else begin
                     mk_raddr = tmp32[IW-1:0];
                     blk_in   = NW'(tmp32);
                     end_in   = NW'(tmp32 + 32'd1);
                     state_in = S_FC;
                  end
               end
               default: begin
               end
            endcase
         end

         // ---- allocate ----
         S_A1: begin
            raddr    = cur_ff;
            state_in = S_A2;
         end
         S_A2: begin
            if (32'(rd_size) == 32'(need_ff)) begin
               res_blk_in = cur_ff;
               rm_node_in = cur_ff;
               ret_rm_in  = S_AX;
               state_in   = S_R0;
            end else begin
               if (32'(rd_size) > 32'(need_ff)) begin
                  best_in   = cur_ff;
                  next_node = rd_smaller;
               end else begin
                  next_node = rd_larger;
               end
               cur_in   = next_node;
               steps_in = steps_ff + 1'b1;
               if (steps_ff == MAXN || !is_node(next_node)) begin
                  state_in = S_A3;
               end else begin
                  state_in = S_A1;
               end
            end
         end
         S_AX: begin
            mk_first_in = cur_ff;
            mk_len_in   = need_ff;
            mk_used_in  = 1'b1;
            state_in    = S_MK0;
         end
         S_A3: begin
            if (!is_node(best_ff)) begin
               res_status_in = ST_NOSPACE;
               state_in      = S_OUT;
            end else begin
               rm_node_in = best_ff;
               ret_rm_in  = S_A4;
               state_in   = S_R0;
            end
         end
         S_A4: begin
            raddr    = best_ff;
            state_in = S_A5;
         end
         S_A5: begin
            // shrink the best range; the new range is carved from its end
            wsize       = NW'(32'(rd_size) - 32'(need_ff));
            waddr       = best_ff;
            wen.size    = 1'b1;
            res_blk_in  = NW'(32'(best_ff) + 32'(wsize));
            ins_from_in = NIL;
            ins_node_in = best_ff;
            ret_ins_in  = S_A6;
            state_in    = S_I0;
         end
         S_A6: begin
            mk_first_in = res_blk_ff;
            mk_len_in   = need_ff;
            mk_used_in  = 1'b1;
            state_in    = S_MK0;
         end

         // ---- free ----
         S_FC: begin
            if (!start_rd_ff || !used_rd_ff) begin
               res_status_in = ST_BADFREE;
               state_in      = S_OUT;
            end else begin
               state_in = S_F1;
            end
         end
         S_F1: begin
            if (end_ff < pool_count_ff) begin
               mk_raddr = end_ff[IW-1:0];
               state_in = S_F1B;
            end else begin
               len_in   = end_ff - blk_ff;
               state_in = S_F2;
            end
         end
         S_F1B: begin
            if (!start_rd_ff) begin
               end_in   = end_ff + 1'b1;
               state_in = S_F1;
            end else begin
               len_in   = end_ff - blk_ff;
               state_in = S_F2;
            end
         end
         S_F2: begin
            tmp32 = 32'(blk_ff) - 32'd1;
            if (blk_ff != '0) begin
               mk_raddr = tmp32[IW-1:0];
               state_in = S_F2B;
            end else begin
               state_in = S_F5;
            end
         end
         S_F2B: begin
            if (!used_rd_ff) begin
               blk_in   = blk_ff - 1'b1;
               state_in = S_F3;
            end else begin
               state_in = S_F5;
            end
         end
         S_F3: begin
            // walk back to the first block of the free range before
            if (blk_ff != '0) begin
               mk_raddr = blk_ff[IW-1:0];
               state_in = S_F3B;
            end else begin
               state_in = S_F4;
            end
         end
         S_F3B: begin
            if (!start_rd_ff) begin
               blk_in   = blk_ff - 1'b1;
               state_in = S_F3;
            end else begin
               state_in = S_F4;
            end
         end
         S_F4: begin
            raddr    = blk_ff;
            state_in = S_F4B;
         end
         S_F4B: begin
            len_in     = len_ff + rd_size;
            rm_node_in = blk_ff;
            ret_rm_in  = S_F5;
            state_in   = S_R0;
         end
         S_F5: begin
            nx32 = 32'(blk_ff) + 32'(len_ff);
            if (nx32 < 32'(pool_count_ff)) begin
               mk_raddr = nx32[IW-1:0];
               nxt_in   = NW'(nx32);
               state_in = S_F5B;
            end else begin
               state_in = S_F7;
            end
         end
         S_F5B: begin
            if (!used_rd_ff) begin
               rm_node_in = nxt_ff;
               ret_rm_in  = S_F6;
               state_in   = S_R0;
            end else begin
               state_in = S_F7;
            end
         end
         S_F6: begin
            raddr    = nxt_ff;
            state_in = S_F6B;
         end
         S_F6B: begin
            len_in   = len_ff + rd_size;
            state_in = S_F7;
         end
         S_F7: begin
            waddr       = blk_ff;
            wen         = '1;
            wsize       = len_ff;
            ins_from_in = NIL;
            ins_node_in = blk_ff;
            ret_ins_in  = S_F8;
            state_in    = S_I0;
         end
         S_F8: begin
            mk_first_in = blk_ff;
            mk_len_in   = NEED_W'(len_ff);
            mk_used_in  = 1'b0;
            state_in    = S_MK0;
         end

         // ---- tree insert of ins_node, walk starting at ins_from ----
         S_I0: begin
            if (!is_node(ins_node_ff)) begin
               state_in = ret_ins_ff;
            end else begin
               raddr    = ins_node_ff;
               state_in = S_I1;
            end
         end
         S_I1: begin
            ins_size_in  = rd_size;
            ins_steps_in = '0;
            if (!is_node(ins_from_ff)) begin
               if (!is_node(root_ff)) begin
                  root_in    = ins_node_ff;
                  waddr      = ins_node_ff;
                  wen.parent = 1'b1;
                  wparent    = NIL;
                  state_in   = ret_ins_ff;
               end else begin
                  ins_from_in = root_ff;
                  state_in    = S_I2;
               end
            end else begin
               state_in = S_I2;
            end
         end
         S_I2: begin
            raddr    = ins_from_ff;
            state_in = S_I3;
         end
         S_I3: begin
            next_node = (rd_size > ins_size_ff) ? rd_smaller : rd_larger;
            if (!is_node(next_node)) begin
               waddr    = ins_from_ff;
               wsmaller = ins_node_ff;
               wlarger  = ins_node_ff;
               if (rd_size > ins_size_ff) begin
                  wen.smaller = 1'b1;
               end else begin
                  wen.larger = 1'b1;
               end
               state_in = S_I4;
            end else if (ins_steps_ff == MAXN) begin
               state_in = ret_ins_ff;
            end else begin
               ins_from_in  = next_node;
               ins_steps_in = ins_steps_ff + 1'b1;
               state_in     = S_I2;
            end
         end
         S_I4: begin
            waddr      = ins_node_ff;
            wen.parent = 1'b1;
            wparent    = ins_from_ff;
            state_in   = ret_ins_ff;
         end

         // ---- tree remove of rm_node; children reinserted from its parent ----
         S_R0: begin
            if (!is_node(rm_node_ff)) begin
               state_in = ret_rm_ff;
            end else begin
               raddr    = rm_node_ff;
               state_in = S_R1;
            end
         end
         S_R1: begin
            rm_sm_in = rd_smaller;
            rm_lg_in = rd_larger;
            if (!is_node(rd_parent)) begin
               rm_par_in = NIL;
               root_in   = NIL;
               state_in  = S_R4;
            end else begin
               rm_par_in = rd_parent;
               state_in  = S_R2;
            end
         end
         S_R2: begin
            raddr    = rm_par_ff;
            state_in = S_R3;
         end
         S_R3: begin
            waddr = rm_par_ff;
            if (rd_smaller == rm_node_ff) begin
               wen.smaller = 1'b1;
            end else if (rd_larger == rm_node_ff) begin
               wen.larger = 1'b1;
            end
            state_in = S_R4;
         end
         S_R4: begin
            if (is_node(rm_sm_ff)) begin
               ins_from_in = rm_par_ff;
               ins_node_in = rm_sm_ff;
               ret_ins_in  = S_R5;
               state_in    = S_I0;
            end else begin
               state_in = S_R6;
            end
         end
         S_R5: begin
            waddr       = rm_node_ff;
            wen.smaller = 1'b1;
            state_in    = S_R6;
         end
         S_R6: begin
            if (is_node(rm_lg_ff)) begin
               ins_from_in = rm_par_ff;
               ins_node_in = rm_lg_ff;
               ret_ins_in  = S_R7;
               state_in    = S_I0;
            end else begin
               state_in = ret_rm_ff;
            end
         end
         S_R7: begin
            waddr      = rm_node_ff;
            wen.larger = 1'b1;
            state_in   = ret_rm_ff;
         end

         // ---- mark a range, one block a cycle ----
         S_MK0: begin
            mk_k_in = '0;
            if (mk_len_ff == '0 ||
                32'(mk_first_ff) + 32'(mk_len_ff) > 32'(pool_count_ff)) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MK1;
            end
         end
         S_MK1: begin
            tmp32        = 32'(mk_first_ff) + 32'(mk_k_ff);
            mk_we        = 1'b1;
            mk_idx       = tmp32[IW-1:0];
            mk_start_val = (mk_k_ff == '0);
            mk_used_val  = mk_used_ff;
            mk_k_in      = mk_k_ff + 1'b1;
            if (mk_k_in == mk_len_ff) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               tmp32 = (res_status_ff == ST_OK) ? 32'(res_blk_ff) : 32'd0;
               rsp_block_in  = tmp32[BLOCK_OUT_W-1:0];
               tmp32         = tmp32 << pool_shift_ff;
               rsp_offset_in = tmp32[OFFSET_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cfg_count_ff  <= COUNT_RESET;
         cfg_shift_ff  <= SHIFT_RESET;
         pool_count_ff <= '0;
         pool_shift_ff <= SHIFT_RESET;
         root_ff       <= NIL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_count_ff  <= cfg_count_in;
         cfg_shift_ff  <= cfg_shift_in;
         pool_count_ff <= pool_count_in;
         pool_shift_ff <= pool_shift_in;
         root_ff       <= root_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mk_we) begin
         start_mem[mk_idx] <= mk_start_val;
         used_mem[mk_idx]  <= mk_used_val;
      end
      start_rd_ff <= start_mem[mk_raddr];
      used_rd_ff  <= used_mem[mk_raddr];
   end

   always_ff @(posedge clock) begin
      ret_ins_ff    <= ret_ins_in;
      ret_rm_ff     <= ret_rm_in;
      kind_ff       <= kind_in;
      bytes_ff      <= bytes_in;
      offset_ff     <= offset_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      steps_ff      <= steps_in;
      blk_ff        <= blk_in;
      end_ff        <= end_in;
      len_ff        <= len_in;
      nxt_ff        <= nxt_in;
      ins_from_ff   <= ins_from_in;
      ins_node_ff   <= ins_node_in;
      ins_size_ff   <= ins_size_in;
      ins_steps_ff  <= ins_steps_in;
      rm_node_ff    <= rm_node_in;
      rm_par_ff     <= rm_par_in;
      rm_sm_ff      <= rm_sm_in;
      rm_lg_ff      <= rm_lg_in;
      mk_first_ff   <= mk_first_in;
      mk_len_ff     <= mk_len_in;
      mk_k_ff       <= mk_k_in;
      mk_used_ff    <= mk_used_in;
      res_status_ff <= res_status_in;
      res_blk_ff    <= res_blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   `BFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, state_ff != S_IDLE, "accepted item did not start")
   `BFA_ASSERT_NOW(a_root_legal, clock, reset, 1'b1, is_node(root_ff) || root_ff == NIL, "tree root is neither a node nor null")
   `BFA_ASSERT_NOW(a_fail_no_block, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_block_index == '0 && rsp_byte_offset == '0, "failed item carries a block")
   `BFA_ASSERT_NEXT(a_out_waits, clock, reset, state_ff == S_OUT && rsp_valid_ff && rsp_stall, state_ff == S_OUT, "result dropped while output held")

endmodule
